// ===== rtl/irc_message_byte_parser_core_macros.svh =====
// assertion macros for the irc message byte parser core
// no dependencies; included by the top level only
`ifndef IRC_MESSAGE_BYTE_PARSER_CORE_MACROS_SVH
`define IRC_MESSAGE_BYTE_PARSER_CORE_MACROS_SVH

`ifndef SYNTH

`define IRC_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define IRC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define IRC_ASSERT_SAME(label, clk, rst, cond, prop)

`define IRC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== rtl/irc_mbp_pkg.sv =====
// types, character constants and codes for the irc message byte parser
// no dependencies
package irc_mbp_pkg;

  typedef enum logic [16:0] {
    PH_START  = 17'h00001,
    PH_KEY    = 17'h00002,
    PH_VAL    = 17'h00004,
    PH_ESC    = 17'h00008,
    PH_TAGSP  = 17'h00010,
    PH_MAIN   = 17'h00020,
    PH_USER   = 17'h00040,
    PH_HOST   = 17'h00080,
    PH_PFXSP  = 17'h00100,
    PH_CMDA   = 17'h00200,
    PH_DIG    = 17'h00400,
    PH_CMDEND = 17'h00800,
    PH_PSP    = 17'h01000,
    PH_MID    = 17'h02000,
    PH_TRAIL  = 17'h04000,
    PH_CR     = 17'h08000,
    PH_DONE   = 17'h10000
  } phase_t;

  localparam logic [3:0] KIND_DELIM   = 4'd0;
  localparam logic [3:0] KIND_KEY     = 4'd1;
  localparam logic [3:0] KIND_VALUE   = 4'd2;
  localparam logic [3:0] KIND_PREFIX  = 4'd3;
  localparam logic [3:0] KIND_USER    = 4'd4;
  localparam logic [3:0] KIND_HOST    = 4'd5;
  localparam logic [3:0] KIND_COMMAND = 4'd6;
  localparam logic [3:0] KIND_MIDDLE  = 4'd7;
  localparam logic [3:0] KIND_TRAIL   = 4'd8;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_EARLY_END   = 4'd1;
  localparam logic [3:0] ERR_BAD_KEY     = 4'd2;
  localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd3;
  localparam logic [3:0] ERR_TAGS_OPEN   = 4'd4;
  localparam logic [3:0] ERR_EMPTY_UH    = 4'd5;
  localparam logic [3:0] ERR_BAD_COMMAND = 4'd6;
  localparam logic [3:0] ERR_EMPTY_MID   = 4'd7;
  localparam logic [3:0] ERR_NO_CR       = 4'd8;
  localparam logic [3:0] ERR_NO_LF       = 4'd9;
  localparam logic [3:0] ERR_TRAIL_JUNK  = 4'd10;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;

  localparam logic [1:0] DIGIT_LAST = 2'd2;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_key_char(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == CH_DASH || b == CH_SLASH || b == CH_PLUS;
  endfunction

  function automatic logic is_line_end(input logic [7:0] b);
    return b == CH_CR || b == CH_LF || b == CH_NUL;
  endfunction

endpackage

// ===== rtl/irc_message_byte_parser_core.sv =====
// irc message byte parser: one input byte per cycle while result_stall is low, one result per byte
// each byte passes an input register (s1) and then a result register; result_stall can hold both
// the parse state is updated once per byte, as the byte moves into the result register
// reset: synchronous, active high; clears both stages and the parse state, sets require_crlf to 1
// depends on irc_mbp_pkg and irc_message_byte_parser_core_macros.svh
`include "irc_message_byte_parser_core_macros.svh"

module irc_message_byte_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [3:0] field_kind,
  output logic       field_open,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [3:0] error_code,
  output logic       message_done,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import irc_mbp_pkg::*;

  logic       require_crlf;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;

  phase_t     phase, phase_next;
  logic [1:0] digit_count, digit_count_next;
  logic       field_has_bytes, field_has_bytes_next;
  logic [3:0] error_held, error_held_next;

  logic [3:0] k;
  logic       o;
  logic       v;
  logic [7:0] d;
  logic [3:0] code;
  logic       may_end;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      require_crlf <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      require_crlf <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  always_comb begin
    phase_next           = phase;
    digit_count_next     = digit_count;
    field_has_bytes_next = field_has_bytes;
    error_held_next      = error_held;
    k = KIND_DELIM;
    o = 1'b0;
    v = 1'b0;
    d = 8'h00;
    if (error_held == ERR_NONE) begin
      case (phase)
        PH_START, PH_TAGSP: begin
          if (phase == PH_START && s1_byte == CH_AT) begin
            phase_next = PH_KEY;
            field_has_bytes_next = 1'b0;
            k = KIND_KEY;
            o = 1'b1;
          end else if (phase == PH_TAGSP && s1_byte == CH_SPACE) begin
            phase_next = phase;
          end else if (s1_byte == CH_COLON) begin
            phase_next = PH_MAIN;
            k = KIND_PREFIX;
            o = 1'b1;
          end else if (is_alpha(s1_byte)) begin
            phase_next = PH_CMDA;
            k = KIND_COMMAND;
            o = 1'b1;
            v = 1'b1;
            d = s1_byte;
          end else if (is_digit(s1_byte)) begin
            phase_next = PH_DIG;
            digit_count_next = 2'd1;
            k = KIND_COMMAND;
            o = 1'b1;
            v = 1'b1;
            d = s1_byte;
          end else begin
            error_held_next = ERR_BAD_COMMAND;
          end
        end
        PH_KEY: begin
          if (is_key_char(s1_byte)) begin
            field_has_bytes_next = 1'b1;
            k = KIND_KEY;
            v = 1'b1;
            d = s1_byte;
          end else if (!field_has_bytes) begin
            error_held_next = ERR_BAD_KEY;
          end else if (s1_byte == CH_EQ) begin
            phase_next = PH_VAL;
            k = KIND_VALUE;
            o = 1'b1;
          end else if (s1_byte == CH_SEMI) begin
            phase_next = PH_KEY;
            field_has_bytes_next = 1'b0;
            k = KIND_KEY;
            o = 1'b1;
          end else if (s1_byte == CH_SPACE) begin
            phase_next = PH_TAGSP;
          end else begin
            error_held_next = ERR_TAGS_OPEN;
          end
        end
        PH_VAL: begin
          if (s1_byte == CH_SEMI) begin
            phase_next = PH_KEY;
            field_has_bytes_next = 1'b0;
            k = KIND_KEY;
            o = 1'b1;
          end else if (s1_byte == CH_SPACE) begin
            phase_next = PH_TAGSP;
          end else if (is_line_end(s1_byte)) begin
            error_held_next = ERR_TAGS_OPEN;
          end else if (s1_byte == CH_BSL) begin
            phase_next = PH_ESC;
            k = KIND_VALUE;
          end else begin
            k = KIND_VALUE;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_ESC: begin
          if (s1_byte == CH_COLON || s1_byte == CH_S || s1_byte == CH_BSL ||
              s1_byte == CH_R || s1_byte == CH_N) begin
            phase_next = PH_VAL;
            k = KIND_VALUE;
            v = 1'b1;
            if (s1_byte == CH_COLON) begin
              d = CH_SEMI;
            end else if (s1_byte == CH_S) begin
              d = CH_SPACE;
            end else if (s1_byte == CH_BSL) begin
              d = CH_BSL;
            end else if (s1_byte == CH_R) begin
              d = CH_CR;
            end else begin
              d = CH_LF;
            end
          end else begin
            error_held_next = ERR_BAD_ESCAPE;
          end
        end
        PH_MAIN: begin
          if (s1_byte == CH_SPACE) begin
            phase_next = PH_PFXSP;
          end else if (s1_byte == CH_BANG) begin
            phase_next = PH_USER;
            field_has_bytes_next = 1'b0;
            k = KIND_USER;
            o = 1'b1;
          end else if (s1_byte == CH_AT) begin
            phase_next = PH_HOST;
            field_has_bytes_next = 1'b0;
            k = KIND_HOST;
            o = 1'b1;
          end else begin
            k = KIND_PREFIX;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_USER: begin
          if (s1_byte == CH_SPACE || s1_byte == CH_AT) begin
            if (!field_has_bytes) begin
              error_held_next = ERR_EMPTY_UH;
            end else if (s1_byte == CH_SPACE) begin
              phase_next = PH_PFXSP;
            end else begin
              phase_next = PH_HOST;
              field_has_bytes_next = 1'b0;
              k = KIND_HOST;
              o = 1'b1;
            end
          end else begin
            field_has_bytes_next = 1'b1;
            k = KIND_USER;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_HOST: begin
          if (s1_byte == CH_SPACE) begin
            if (!field_has_bytes) begin
              error_held_next = ERR_EMPTY_UH;
            end else begin
              phase_next = PH_PFXSP;
            end
          end else begin
            field_has_bytes_next = 1'b1;
            k = KIND_HOST;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_PFXSP: begin
          if (s1_byte == CH_SPACE) begin
            phase_next = phase;
          end else if (is_alpha(s1_byte)) begin
            phase_next = PH_CMDA;
            k = KIND_COMMAND;
            o = 1'b1;
            v = 1'b1;
            d = s1_byte;
          end else if (is_digit(s1_byte)) begin
            phase_next = PH_DIG;
            digit_count_next = 2'd1;
            k = KIND_COMMAND;
            o = 1'b1;
            v = 1'b1;
            d = s1_byte;
          end else begin
            error_held_next = ERR_BAD_COMMAND;
          end
        end
        PH_CMDA, PH_CMDEND: begin
          if (phase == PH_CMDA && is_alpha(s1_byte)) begin
            k = KIND_COMMAND;
            v = 1'b1;
            d = s1_byte;
          end else if (s1_byte == CH_SPACE) begin
            phase_next = PH_PSP;
          end else if (require_crlf && s1_byte == CH_CR) begin
            phase_next = PH_CR;
          end else begin
            error_held_next = require_crlf ? ERR_NO_CR : ERR_TRAIL_JUNK;
          end
        end
        PH_DIG: begin
          if (!is_digit(s1_byte)) begin
            error_held_next = ERR_BAD_COMMAND;
          end else begin
            if (digit_count >= DIGIT_LAST) begin
              phase_next = PH_CMDEND;
            end else begin
              digit_count_next = digit_count + 2'd1;
            end
            k = KIND_COMMAND;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_PSP: begin
          if (s1_byte == CH_SPACE) begin
            phase_next = phase;
          end else if (s1_byte == CH_COLON) begin
            phase_next = PH_TRAIL;
            k = KIND_TRAIL;
            o = 1'b1;
          end else if (is_line_end(s1_byte)) begin
            error_held_next = ERR_EMPTY_MID;
          end else begin
            phase_next = PH_MID;
            k = KIND_MIDDLE;
            o = 1'b1;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_MID, PH_TRAIL: begin
          if (phase == PH_MID && s1_byte == CH_SPACE) begin
            phase_next = PH_PSP;
          end else if (is_line_end(s1_byte)) begin
            if (require_crlf && s1_byte == CH_CR) begin
              phase_next = PH_CR;
            end else begin
              error_held_next = require_crlf ? ERR_NO_CR : ERR_TRAIL_JUNK;
            end
          end else begin
            k = (phase == PH_MID) ? KIND_MIDDLE : KIND_TRAIL;
            v = 1'b1;
            d = s1_byte;
          end
        end
        PH_CR: begin
          if (s1_byte == CH_LF) begin
            phase_next = PH_DONE;
          end else begin
            error_held_next = ERR_NO_LF;
          end
        end
        default: begin
          error_held_next = ERR_TRAIL_JUNK;
        end
      endcase
    end

    // an error byte and later bytes carry nothing
    if (error_held_next != ERR_NONE) begin
      k = KIND_DELIM;
      o = 1'b0;
      v = 1'b0;
      d = 8'h00;
    end

    may_end = (phase_next == PH_DONE) ||
              (!require_crlf && (phase_next == PH_CMDA || phase_next == PH_CMDEND ||
                                 phase_next == PH_PSP || phase_next == PH_MID ||
                                 phase_next == PH_TRAIL));
    code = error_held_next;
    if (s1_last) begin
      if (code == ERR_NONE && !may_end) begin
        code = ERR_EARLY_END;
      end
      phase_next           = PH_START;
      digit_count_next     = 2'd0;
      field_has_bytes_next = 1'b0;
      error_held_next      = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      digit_count     <= 2'd0;
      field_has_bytes <= 1'b0;
      error_held      <= ERR_NONE;
    end else if (s1_adv) begin
      phase           <= phase_next;
      digit_count     <= digit_count_next;
      field_has_bytes <= field_has_bytes_next;
      error_held      <= error_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      field_kind   <= k;
      field_open   <= o;
      out_valid    <= v;
      out_byte     <= d;
      error_code   <= code;
      message_done <= s1_last;
    end
  end

  // held error suppresses the byte
  `IRC_ASSERT_NEXT(a_err_quiet, clk, rst, s1_adv && error_held != ERR_NONE,
    field_kind == KIND_DELIM && !out_valid && !field_open && error_code != ERR_NONE)

  // last byte restarts the parse
  `IRC_ASSERT_NEXT(a_last_restart, clk, rst, s1_adv && s1_last,
    phase == PH_START && error_held == ERR_NONE && message_done)

  // a carried byte always belongs to a field
  `IRC_ASSERT_SAME(a_byte_kind, clk, rst, result_valid && out_valid,
    field_kind != KIND_DELIM && (message_done || error_code == ERR_NONE))

endmodule

// ===== sim/irc_message_byte_parser_core_tb.sv =====
// self-checking testbench for irc_message_byte_parser_core: directed table, then random irc lines
// each accepted byte runs through a local parser model; its report (or a pinned one) is queued
// depends on irc_mbp_pkg and the rtl of irc_message_byte_parser_core
`timescale 1ns / 100ps

module irc_message_byte_parser_core_tb;
  import irc_mbp_pkg::*;

  typedef struct packed {
    logic [3:0] kind;
    logic       open;
    logic       valid;
    logic [7:0] data;
    logic [3:0] err;
    logic       done;
  } field_report_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t       op;
    logic [7:0]    b;
    logic          last;
    logic          pinned;
    field_report_t want;
  } dir_row_t;

  localparam field_report_t NO_PIN = '0;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int HOLD_AT = 240;
  localparam int HOLD_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [3:0] field_kind;
  logic       field_open;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [3:0] error_code;
  logic       message_done;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;

  // local parser state
  phase_t     ph = PH_START;
  logic [1:0] digits = 2'd0;
  logic       has_bytes = 1'b0;
  logic [3:0] err_held = ERR_NONE;
  logic       crlf_req = 1'b1;
  field_report_t rep;

  field_report_t pending_reports [$];
  logic [7:0]    line_bytes [$];
  field_report_t pin_res = NO_PIN;
  logic          pin_on = 1'b0;
  logic          steady = 1'b0;
  logic          hold_done = 1'b0;
  int            hold_left = 0;
  int            sent_count = 0;
  int            reports_seen = 0;
  int            mismatches = 0;

  dir_row_t dir_rows [20] = '{
    '{ROW_BYTE, CH_COLON, 1'b0, 1'b1, '{KIND_PREFIX, 1'b1, 1'b0, 8'h00, ERR_NONE, 1'b0}},
    '{ROW_BYTE, CH_SPACE, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, "P", 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, CH_CR, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, CH_LF, 1'b1, 1'b1, '{KIND_DELIM, 1'b0, 1'b0, 8'h00, ERR_NONE, 1'b1}},
    '{ROW_BYTE, CH_AT, 1'b0, 1'b1, '{KIND_KEY, 1'b1, 1'b0, 8'h00, ERR_NONE, 1'b0}},
    '{ROW_BYTE, CH_EQ, 1'b1, 1'b1, '{KIND_DELIM, 1'b0, 1'b0, 8'h00, ERR_BAD_KEY, 1'b1}},
    '{ROW_BYTE, CH_AT, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, "k", 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, CH_EQ, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, 8'hff, 1'b0, 1'b1, '{KIND_VALUE, 1'b0, 1'b1, 8'hff, ERR_NONE, 1'b0}},
    '{ROW_BYTE, CH_BSL, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, "q", 1'b1, 1'b1, '{KIND_DELIM, 1'b0, 1'b0, 8'h00, ERR_BAD_ESCAPE, 1'b1}},
    '{ROW_BYTE, "A", 1'b1, 1'b1, '{KIND_COMMAND, 1'b1, 1'b1, "A", ERR_EARLY_END, 1'b1}},
    '{ROW_BYTE, "Z", 1'b0, 1'b0, NO_PIN},
    '{ROW_CFG, 8'h00, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, "Z", 1'b1, 1'b0, NO_PIN},
    '{ROW_BYTE, "Q", 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, CH_SPACE, 1'b0, 1'b0, NO_PIN},
    '{ROW_BYTE, CH_NUL, 1'b1, 1'b1, '{KIND_DELIM, 1'b0, 1'b0, 8'h00, ERR_EMPTY_MID, 1'b1}}
  };

  irc_message_byte_parser_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .field_kind   (field_kind),
    .field_open   (field_open),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .error_code   (error_code),
    .message_done (message_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit letter_ch(input logic [7:0] b);
    return b inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic bit digit_ch(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic bit key_ch(input logic [7:0] b);
    return letter_ch(b) || digit_ch(b) || (b inside {CH_DASH, CH_SLASH, CH_PLUS});
  endfunction

  function automatic bit eol_ch(input logic [7:0] b);
    return b inside {CH_CR, CH_LF, CH_NUL};
  endfunction

  function automatic void keep_report(input field_report_t r);
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  function automatic void note(input logic [3:0] kind, input logic open, input logic valid,
                               input logic [7:0] data);
    rep.kind = kind;
    rep.open = open;
    rep.valid = valid;
    rep.data = data;
  endfunction

  function automatic void open_key();
    ph = PH_KEY;
    has_bytes = 1'b0;
    note(KIND_KEY, 1'b1, 1'b0, 8'h00);
  endfunction

  function automatic void line_stop(input logic [7:0] b);
    if (crlf_req && b == CH_CR) begin
      ph = PH_CR;
    end else begin
      err_held = crlf_req ? ERR_NO_CR : ERR_TRAIL_JUNK;
    end
  endfunction

  function automatic void after_command(input logic [7:0] b);
    if (b == CH_SPACE) begin
      ph = PH_PSP;
    end else begin
      line_stop(b);
    end
  endfunction

  function automatic void command_first(input logic [7:0] b);
    if (letter_ch(b)) begin
      ph = PH_CMDA;
      note(KIND_COMMAND, 1'b1, 1'b1, b);
    end else if (digit_ch(b)) begin
      ph = PH_DIG;
      digits = 2'd1;
      note(KIND_COMMAND, 1'b1, 1'b1, b);
    end else begin
      err_held = ERR_BAD_COMMAND;
    end
  endfunction

  function automatic void pre_command(input logic [7:0] b);
    if (b == CH_COLON) begin
      ph = PH_MAIN;
      note(KIND_PREFIX, 1'b1, 1'b0, 8'h00);
    end else begin
      command_first(b);
    end
  endfunction

  function automatic bit end_allowed();
    return ph == PH_DONE ||
           (!crlf_req && (ph inside {PH_CMDA, PH_CMDEND, PH_PSP, PH_MID, PH_TRAIL}));
  endfunction

  function automatic field_report_t classify_byte(input logic [7:0] b, input logic last);
    logic [7:0] d;
    logic       bad;
    rep = '0;
    d = 8'h00;
    bad = 1'b0;
    if (err_held == ERR_NONE) begin
      case (ph)
        PH_START: begin
          if (b == CH_AT) open_key();
          else pre_command(b);
        end
        PH_KEY: begin
          if (key_ch(b)) begin
            has_bytes = 1'b1;
            note(KIND_KEY, 1'b0, 1'b1, b);
          end else if (!has_bytes) begin
            err_held = ERR_BAD_KEY;
          end else if (b == CH_EQ) begin
            ph = PH_VAL;
            note(KIND_VALUE, 1'b1, 1'b0, 8'h00);
          end else if (b == CH_SEMI) begin
            open_key();
          end else if (b == CH_SPACE) begin
            ph = PH_TAGSP;
          end else begin
            err_held = ERR_TAGS_OPEN;
          end
        end
        PH_VAL: begin
          if (b == CH_SEMI) begin
            open_key();
          end else if (b == CH_SPACE) begin
            ph = PH_TAGSP;
          end else if (eol_ch(b)) begin
            err_held = ERR_TAGS_OPEN;
          end else if (b == CH_BSL) begin
            ph = PH_ESC;
            note(KIND_VALUE, 1'b0, 1'b0, 8'h00);
          end else begin
            note(KIND_VALUE, 1'b0, 1'b1, b);
          end
        end
        PH_ESC: begin
          case (b)
            CH_COLON: d = CH_SEMI;
            CH_S:     d = CH_SPACE;
            CH_BSL:   d = CH_BSL;
            CH_R:     d = CH_CR;
            CH_N:     d = CH_LF;
            default:  bad = 1'b1;
          endcase
          if (bad) begin
            err_held = ERR_BAD_ESCAPE;
          end else begin
            ph = PH_VAL;
            note(KIND_VALUE, 1'b0, 1'b1, d);
          end
        end
        PH_TAGSP: begin
          if (b != CH_SPACE) pre_command(b);
        end
        PH_MAIN: begin
          if (b == CH_SPACE) begin
            ph = PH_PFXSP;
          end else if (b == CH_BANG) begin
            ph = PH_USER;
            has_bytes = 1'b0;
            note(KIND_USER, 1'b1, 1'b0, 8'h00);
          end else if (b == CH_AT) begin
            ph = PH_HOST;
            has_bytes = 1'b0;
            note(KIND_HOST, 1'b1, 1'b0, 8'h00);
          end else begin
            note(KIND_PREFIX, 1'b0, 1'b1, b);
          end
        end
        PH_USER: begin
          if (b == CH_SPACE || b == CH_AT) begin
            if (!has_bytes) begin
              err_held = ERR_EMPTY_UH;
            end else if (b == CH_SPACE) begin
              ph = PH_PFXSP;
            end else begin
              ph = PH_HOST;
              has_bytes = 1'b0;
              note(KIND_HOST, 1'b1, 1'b0, 8'h00);
            end
          end else begin
            has_bytes = 1'b1;
            note(KIND_USER, 1'b0, 1'b1, b);
          end
        end
        PH_HOST: begin
          if (b == CH_SPACE) begin
            if (!has_bytes) err_held = ERR_EMPTY_UH;
            else ph = PH_PFXSP;
          end else begin
            has_bytes = 1'b1;
            note(KIND_HOST, 1'b0, 1'b1, b);
          end
        end
        PH_PFXSP: begin
          if (b != CH_SPACE) command_first(b);
        end
        PH_CMDA: begin
          if (letter_ch(b)) note(KIND_COMMAND, 1'b0, 1'b1, b);
          else after_command(b);
        end
        PH_DIG: begin
          if (!digit_ch(b)) begin
            err_held = ERR_BAD_COMMAND;
          end else begin
            if (digits >= DIGIT_LAST) ph = PH_CMDEND;
            else digits = digits + 2'd1;
            note(KIND_COMMAND, 1'b0, 1'b1, b);
          end
        end
        PH_CMDEND: after_command(b);
        PH_PSP: begin
          if (b == CH_COLON) begin
            ph = PH_TRAIL;
            note(KIND_TRAIL, 1'b1, 1'b0, 8'h00);
          end else if (eol_ch(b)) begin
            err_held = ERR_EMPTY_MID;
          end else if (b != CH_SPACE) begin
            ph = PH_MID;
            note(KIND_MIDDLE, 1'b1, 1'b1, b);
          end
        end
        PH_MID: begin
          if (b == CH_SPACE) ph = PH_PSP;
          else if (eol_ch(b)) line_stop(b);
          else note(KIND_MIDDLE, 1'b0, 1'b1, b);
        end
        PH_TRAIL: begin
          if (eol_ch(b)) line_stop(b);
          else note(KIND_TRAIL, 1'b0, 1'b1, b);
        end
        PH_CR: begin
          if (b == CH_LF) ph = PH_DONE;
          else err_held = ERR_NO_LF;
        end
        default: err_held = ERR_TRAIL_JUNK;
      endcase
    end
    // an error wipes whatever the byte would have reported
    if (err_held != ERR_NONE) rep = '0;
    rep.err = err_held;
    rep.done = last;
    if (last) begin
      if (err_held == ERR_NONE && !end_allowed()) rep.err = ERR_EARLY_END;
      ph = PH_START;
      digits = 2'd0;
      has_bytes = 1'b0;
      err_held = ERR_NONE;
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    mismatches++;
    if (mismatches <= 100) begin
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               what, reports_seen, seen, wanted);
    end
  endtask

  always @(posedge clk) begin
    field_report_t got;
    field_report_t want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        want = classify_byte(in_byte, in_last);
        keep_report(pin_on ? pin_res : want);
        sent_count++;
      end
      if (result_valid && !result_stall) begin
        got = '{field_kind, field_open, out_valid, out_byte, error_code, message_done};
        if (pending_reports.size() == 0) begin
          report_mismatch("result_valid", 1, 0);
        end else begin
          want = pending_reports.pop_front();
          if (got.kind !== want.kind) report_mismatch("field_kind", got.kind, want.kind);
          if (got.open !== want.open) report_mismatch("field_open", got.open, want.open);
          if (got.valid !== want.valid) report_mismatch("out_valid", got.valid, want.valid);
          if (got.data !== want.data) report_mismatch("out_byte", got.data, want.data);
          if (got.err !== want.err) report_mismatch("error_code", got.err, want.err);
          if (got.done !== want.done) report_mismatch("message_done", got.done, want.done);
        end
        reports_seen++;
      end
    end
  end

  // result side: random stall, one long hold-off once the input has run for a while
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 6);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic pin,
                           input field_report_t want);
    while (!steady && $urandom_range(99) < 6) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    pin_on = pin;
    pin_res = want;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_crlf(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    crlf_req = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] letter_byte();
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] key_byte();
    case ($urandom_range(5))
      0, 1:    return letter_byte();
      2:       return 8'h30 + 8'($urandom_range(9));
      3:       return CH_DASH;
      4:       return CH_SLASH;
      default: return CH_PLUS;
    endcase
  endfunction

  function automatic logic [7:0] escape_byte();
    case ($urandom_range(4))
      0:       return CH_COLON;
      1:       return CH_S;
      2:       return CH_BSL;
      3:       return CH_R;
      default: return CH_N;
    endcase
  endfunction

  function automatic logic [7:0] text_byte(input logic [7:0] x1, input logic [7:0] x2,
                                           input logic [7:0] x3);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (eol_ch(b) || b == x1 || b == x2 || b == x3);
    return b;
  endfunction

  // one irc line, mostly well formed, sometimes corrupted, cut short or plain noise
  task automatic compose_line(input logic crlf);
    int n;
    int cut;
    int pick;
    line_bytes.delete();
    if ($urandom_range(99) < 40) begin
      add_byte(CH_AT);
      n = $urandom_range(3, 1);
      for (int t = 0; t < n; t++) begin
        if (t != 0) add_byte(CH_SEMI);
        repeat ($urandom_range(4, 1)) add_byte(key_byte());
        if ($urandom_range(1)) begin
          add_byte(CH_EQ);
          repeat ($urandom_range(4)) begin
            if ($urandom_range(4) == 0) begin
              add_byte(CH_BSL);
              add_byte(escape_byte());
            end else begin
              add_byte(text_byte(CH_SEMI, CH_SPACE, CH_BSL));
            end
          end
        end
      end
      repeat ($urandom_range(2, 1)) add_byte(CH_SPACE);
    end
    if ($urandom_range(99) < 40) begin
      add_byte(CH_COLON);
      repeat ($urandom_range(4)) add_byte(text_byte(CH_SPACE, CH_BANG, CH_AT));
      if ($urandom_range(1)) begin
        add_byte(CH_BANG);
        repeat ($urandom_range(3, 1)) add_byte(text_byte(CH_SPACE, CH_AT, CH_NUL));
      end
      if ($urandom_range(1)) begin
        add_byte(CH_AT);
        repeat ($urandom_range(3, 1)) add_byte(text_byte(CH_SPACE, CH_NUL, CH_NUL));
      end
      repeat ($urandom_range(2, 1)) add_byte(CH_SPACE);
    end
    if ($urandom_range(1)) begin
      repeat ($urandom_range(5, 1)) add_byte(letter_byte());
    end else begin
      repeat (3) add_byte(8'h30 + 8'($urandom_range(9)));
    end
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(2, 1)) add_byte(CH_SPACE);
      add_byte(text_byte(CH_SPACE, CH_COLON, CH_NUL));
      repeat ($urandom_range(3)) add_byte(text_byte(CH_SPACE, CH_NUL, CH_NUL));
    end
    if ($urandom_range(1)) begin
      add_byte(CH_SPACE);
      add_byte(CH_COLON);
      repeat ($urandom_range(5)) add_byte(text_byte(CH_NUL, CH_NUL, CH_NUL));
    end
    if (crlf) begin
      add_byte(CH_CR);
      add_byte(CH_LF);
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (pick < 18) begin
      cut = $urandom_range(line_bytes.size() - 1, 1);
      while (line_bytes.size() > cut) void'(line_bytes.pop_back());
    end else if (pick < 25) begin
      line_bytes.delete();
      repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int sent;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_CFG) begin
        settle();
        write_crlf(dir_rows[r].b[0]);
      end else begin
        send_byte(dir_rows[r].b, dir_rows[r].last, dir_rows[r].pinned, dir_rows[r].want);
      end
    end
    for (int p = 0; p < 4; p++) begin
      settle();
      write_crlf(p % 2 == 0);
      steady = (p == 2);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        compose_line(crlf_req);
        foreach (line_bytes[i]) begin
          send_byte(line_bytes[i], i == line_bytes.size() - 1, 1'b0, NO_PIN);
        end
        sent += line_bytes.size();
      end
    end
    steady = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
